// ===== hw/rtl/pcf_pkg.sv =====
package pcf_pkg;

	localparam int MAX_PARTICLES_DEF = 64;

	localparam int POS_W   = 24;
	localparam int CHG_W   = 16;
	localparam int FORCE_W = 48;
	localparam int CUT_W   = 52;
	localparam int GAIN_W  = 32;
	localparam int CFG_IDX_W = 1;

	localparam int DIFF_W  = POS_W + 1;
	localparam int AD_W    = POS_W;
	localparam int AQ_W    = 31;
	localparam int R2_W    = 50;
	localparam int ROOT_W  = 25;
	localparam int SREM_W  = 28;
	localparam int NUM_W   = 62;
	localparam int DEN_W   = R2_W + ROOT_W;
	localparam int REM_W   = NUM_W + 24;
	localparam int DSH_W   = DEN_W + 47;
	localparam int MAG_W   = 48;
	localparam int TERM_W  = MAG_W + 1;
	localparam int TFULL_W = 73;
	localparam int MUL_W   = 32;
	localparam int PROD_W  = 2 * MUL_W;

	localparam int SQRT_STEPS = 25;
	localparam int DIV_STEPS  = 48;
	localparam int STEP_W     = 6;

	localparam logic [CUT_W-1:0]  CUTOFF_RST = {CUT_W{1'b1}};
	localparam logic [GAIN_W-1:0] GAIN_RST   = 32'h0001_0000;
	localparam logic [MAG_W-1:0]  MAG_LIM    = 48'h8000_0000_0000;

	localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 1'b1;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic signed [CHG_W-1:0] charge;
		logic                    last_particle;
	} particle_t;

	typedef struct packed {
		logic signed [FORCE_W-1:0] force_x;
		logic signed [FORCE_W-1:0] force_y;
		logic signed [FORCE_W-1:0] force_z;
		logic                      last_force;
	} result_t;

	typedef enum logic [3:0] {
		MUL_NONE, MUL_SQX, MUL_SQY, MUL_SQZ, MUL_Q, MUL_NUM,
		MUL_DEN0, MUL_DEN1, MUL_T0, MUL_T1
	} mul_op_t;

	typedef enum logic [1:0] {AXIS_X, AXIS_Y, AXIS_Z} axis_t;

	typedef enum logic [1:0] {ACC_NONE, ACC_ZERO, ACC_ADD, ACC_SUB} acc_wr_t;

	typedef struct packed {
		logic    store_we;
		logic    diff_ld;
		mul_op_t mul_op;
		axis_t   axis;
		logic    sqrt_ld;
		logic    sqrt_step;
		logic    div_ld;
		logic    div_step;
		acc_wr_t acc_wr;
		logic    out_ld;
		logic    out_last;
	} dp_cmd_t;

	typedef struct packed {
		logic skip;
	} dp_sts_t;

endpackage

// ===== hw/rtl/pairwise_coulomb_force_cutoff.sv =====
// Loads particles one word per cycle into an internal store of MAX_PARTICLES entries; a
// particle arriving at a full store is dropped, but its last flag still closes the set.
// After the last particle the block clears N accumulators, then evaluates all
// N(N-1)/2 pairs on one shared 32x32 multiplier with a bit-serial square root and a
// restoring divider; a pair skipped by the cutoff or zero distance bypasses the root
// and divide. Results are then read out in load order. No new particle is taken until
// the last result word is accepted. Configuration writes are always accepted and must
// only be made while idle.
module pairwise_coulomb_force_cutoff import pcf_pkg::*; #(
	parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 particle_valid,
	output logic                 particle_ready,
	input  particle_t            particle,
	output logic                 result_valid,
	input  logic                 result_ready,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CUT_W-1:0]     cfg_data
);

	localparam int IW = $clog2(MAX_PARTICLES);

	dp_cmd_t       cmd;
	dp_sts_t       sts;
	logic [IW-1:0] st_waddr, st_raddr_i, st_raddr_j, acc_waddr, acc_raddr;

	assign cfg_ready = 1'b1;

	pcf_ctrl #(.MAX_PARTICLES(MAX_PARTICLES)) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.particle_valid (particle_valid),
		.particle_ready (particle_ready),
		.last_in        (particle.last_particle),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.st_waddr       (st_waddr),
		.st_raddr_i     (st_raddr_i),
		.st_raddr_j     (st_raddr_j),
		.acc_waddr      (acc_waddr),
		.acc_raddr      (acc_raddr),
		.cmd            (cmd),
		.sts            (sts)
	);

	pcf_datapath #(.MAX_PARTICLES(MAX_PARTICLES)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.particle   (particle),
		.st_waddr   (st_waddr),
		.st_raddr_i (st_raddr_i),
		.st_raddr_j (st_raddr_j),
		.acc_waddr  (acc_waddr),
		.acc_raddr  (acc_raddr),
		.cmd        (cmd),
		.sts        (sts),
		.result     (result)
	);

endmodule

// ===== hw/rtl/pcf_datapath.sv =====
module pcf_datapath import pcf_pkg::*; #(
	parameter int MAX_PARTICLES = MAX_PARTICLES_DEF,
	localparam int IW = $clog2(MAX_PARTICLES)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CUT_W-1:0]     cfg_data,
	input  particle_t            particle,
	input  logic [IW-1:0]        st_waddr,
	input  logic [IW-1:0]        st_raddr_i,
	input  logic [IW-1:0]        st_raddr_j,
	input  logic [IW-1:0]        acc_waddr,
	input  logic [IW-1:0]        acc_raddr,
	input  dp_cmd_t              cmd,
	output dp_sts_t              sts,
	output result_t              result
);

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
		logic signed [CHG_W-1:0] q;
	} store_word_t;

	typedef struct packed {
		logic signed [FORCE_W-1:0] x;
		logic signed [FORCE_W-1:0] y;
		logic signed [FORCE_W-1:0] z;
	} acc_word_t;

	function automatic logic [FORCE_W-1:0] sat_sum(logic [FORCE_W+1:0] s);
		logic [FORCE_W-1:0] r;
		if (s[FORCE_W+1:FORCE_W-1] == 3'b000 || s[FORCE_W+1:FORCE_W-1] == 3'b111) begin
			r = s[FORCE_W-1:0];
		end else if (s[FORCE_W+1]) begin
			r = {1'b1, {(FORCE_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(FORCE_W-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic logic [FORCE_W-1:0] acc_add(logic [FORCE_W-1:0] a,
			logic [TERM_W-1:0] t);
		return sat_sum({{2{a[FORCE_W-1]}}, a} + {t[TERM_W-1], t});
	endfunction

	function automatic logic [FORCE_W-1:0] acc_sub(logic [FORCE_W-1:0] a,
			logic [TERM_W-1:0] t);
		return sat_sum({{2{a[FORCE_W-1]}}, a} - {t[TERM_W-1], t});
	endfunction

	logic [CUT_W-1:0]  cutoff_q;
	logic [GAIN_W-1:0] gain_q;

	store_word_t store_mem [MAX_PARTICLES];
	store_word_t rdi_q, rdj_q;
	acc_word_t   acc_mem [MAX_PARTICLES];
	acc_word_t   acc_rd_q, acc_wdata;

	logic [AD_W-1:0]  ad_x_q, ad_y_q, ad_z_q;
	logic             neg_x_q, neg_y_q, neg_z_q, qneg_q;
	logic [CHG_W-1:0] aqi_q, aqj_q;
	logic [AQ_W-1:0]  aq_q;
	logic [R2_W-1:0]  r2_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;

	logic [R2_W-1:0]   sv_q;
	logic [SREM_W-1:0] srem_q;
	logic [ROOT_W-1:0] root_q;
	logic [SREM_W-1:0] srem_n, strial;

	logic [REM_W-1:0] rem_q;
	logic [DSH_W-1:0] dsh_q;
	logic [MAG_W-1:0] quo_q, mag;

	logic [MUL_W-1:0]  mul_a, mul_b;
	logic [PROD_W-1:0] prod_s1;
	mul_op_t           op_s1;
	axis_t             axis_s1;

	logic [MAG_W-1:0]   tacc_q, tm;
	logic [TFULL_W-1:0] tfull;
	logic               tneg;
	logic [TERM_W-1:0]  tval;
	logic [TERM_W-1:0]  term_x_q, term_y_q, term_z_q;
	logic [AD_W-1:0]    ad_sel;

	logic signed [DIFF_W-1:0] dx, dy, dz;
	logic signed [CHG_W:0]    qi_e, qj_e, aqi_n, aqj_n;
	logic [DIFF_W-1:0]        ax_n, ay_n, az_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= CUTOFF_RST;
			gain_q <= GAIN_RST;
			op_s1 <= MUL_NONE;
			axis_s1 <= AXIS_X;
		end else begin
			op_s1 <= cmd.mul_op;
			axis_s1 <= cmd.axis;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_CUTOFF: cutoff_q <= cfg_data;
					CFG_GAIN:   gain_q <= cfg_data[GAIN_W-1:0];
					default:    ;
				endcase
			end
		end
	end

	// Particle store: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (cmd.store_we) begin
			store_mem[st_waddr] <= '{x: particle.pos_x, y: particle.pos_y,
				z: particle.pos_z, q: particle.charge};
		end
		rdi_q <= store_mem[st_raddr_i];
		rdj_q <= store_mem[st_raddr_j];
	end

	always_comb begin
		dx = {rdi_q.x[POS_W-1], rdi_q.x} - {rdj_q.x[POS_W-1], rdj_q.x};
		dy = {rdi_q.y[POS_W-1], rdi_q.y} - {rdj_q.y[POS_W-1], rdj_q.y};
		dz = {rdi_q.z[POS_W-1], rdi_q.z} - {rdj_q.z[POS_W-1], rdj_q.z};
		ax_n = dx[DIFF_W-1] ? -dx : dx;
		ay_n = dy[DIFF_W-1] ? -dy : dy;
		az_n = dz[DIFF_W-1] ? -dz : dz;
		qi_e = {rdi_q.q[CHG_W-1], rdi_q.q};
		qj_e = {rdj_q.q[CHG_W-1], rdj_q.q};
		aqi_n = qi_e[CHG_W] ? -qi_e : qi_e;
		aqj_n = qj_e[CHG_W] ? -qj_e : qj_e;
	end

	always_comb begin
		case (cmd.axis)
			AXIS_X:  ad_sel = ad_x_q;
			AXIS_Y:  ad_sel = ad_y_q;
			AXIS_Z:  ad_sel = ad_z_q;
			default: ad_sel = ad_x_q;
		endcase
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_op)
			MUL_SQX: begin
				mul_a = MUL_W'(ad_x_q);
				mul_b = MUL_W'(ad_x_q);
			end
			MUL_SQY: begin
				mul_a = MUL_W'(ad_y_q);
				mul_b = MUL_W'(ad_y_q);
			end
			MUL_SQZ: begin
				mul_a = MUL_W'(ad_z_q);
				mul_b = MUL_W'(ad_z_q);
			end
			MUL_Q: begin
				mul_a = MUL_W'(aqi_q);
				mul_b = MUL_W'(aqj_q);
			end
			MUL_NUM: begin
				mul_a = gain_q;
				mul_b = MUL_W'(aq_q);
			end
			MUL_DEN0: begin
				mul_a = MUL_W'(r2_q[ROOT_W-1:0]);
				mul_b = MUL_W'(root_q);
			end
			MUL_DEN1: begin
				mul_a = MUL_W'(r2_q[R2_W-1:ROOT_W]);
				mul_b = MUL_W'(root_q);
			end
			MUL_T0: begin
				mul_a = MUL_W'(mag[AD_W-1:0]);
				mul_b = MUL_W'(ad_sel);
			end
			MUL_T1: begin
				mul_a = MUL_W'(mag[MAG_W-1:AD_W]);
				mul_b = MUL_W'(ad_sel);
			end
			default: ;
		endcase
	end

	// Square root step: bring down two bits, try root*4+1.
	always_comb begin
		srem_n = {srem_q[SREM_W-3:0], sv_q[R2_W-1:R2_W-2]};
		strial = {1'b0, root_q, 2'b01};
	end

	// A quotient bit at the top position means the result is at least the clamp value.
	assign mag = quo_q[MAG_W-1] ? MAG_LIM : quo_q;

	always_comb begin
		tfull = {{(TFULL_W-MAG_W){1'b0}}, tacc_q}
			+ {1'b0, prod_s1[MAG_W-1:0], {AD_W{1'b0}}};
		tm = (tfull > {{(TFULL_W-MAG_W){1'b0}}, MAG_LIM}) ? MAG_LIM : tfull[MAG_W-1:0];
		case (axis_s1)
			AXIS_X:  tneg = qneg_q ^ neg_x_q;
			AXIS_Y:  tneg = qneg_q ^ neg_y_q;
			AXIS_Z:  tneg = qneg_q ^ neg_z_q;
			default: tneg = qneg_q;
		endcase
		tval = tneg ? ({TERM_W{1'b0}} - {1'b0, tm}) : {1'b0, tm};
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(mul_a) * PROD_W'(mul_b);
		if (cmd.diff_ld) begin
			ad_x_q <= ax_n[AD_W-1:0];
			ad_y_q <= ay_n[AD_W-1:0];
			ad_z_q <= az_n[AD_W-1:0];
			neg_x_q <= dx[DIFF_W-1];
			neg_y_q <= dy[DIFF_W-1];
			neg_z_q <= dz[DIFF_W-1];
			aqi_q <= aqi_n[CHG_W-1:0];
			aqj_q <= aqj_n[CHG_W-1:0];
			qneg_q <= rdi_q.q[CHG_W-1] ^ rdj_q.q[CHG_W-1];
		end
		case (op_s1)
			MUL_SQX:  r2_q <= R2_W'(prod_s1[2*AD_W-1:0]);
			MUL_SQY:  r2_q <= r2_q + R2_W'(prod_s1[2*AD_W-1:0]);
			MUL_SQZ:  r2_q <= r2_q + R2_W'(prod_s1[2*AD_W-1:0]);
			MUL_Q:    aq_q <= prod_s1[AQ_W-1:0];
			MUL_NUM:  num_q <= prod_s1[NUM_W-1:0];
			MUL_DEN0: den_q <= DEN_W'(prod_s1[2*ROOT_W-1:0]);
			MUL_DEN1: den_q <= den_q + {prod_s1[2*ROOT_W-1:0], {ROOT_W{1'b0}}};
			MUL_T0:   tacc_q <= prod_s1[MAG_W-1:0];
			MUL_T1: begin
				case (axis_s1)
					AXIS_X:  term_x_q <= tval;
					AXIS_Y:  term_y_q <= tval;
					AXIS_Z:  term_z_q <= tval;
					default: ;
				endcase
			end
			default: ;
		endcase
		if (cmd.sqrt_ld) begin
			sv_q <= r2_q;
			srem_q <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			sv_q <= {sv_q[R2_W-3:0], 2'b00};
			if (srem_n >= strial) begin
				srem_q <= srem_n - strial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				srem_q <= srem_n;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
		if (cmd.div_ld) begin
			rem_q <= {num_q, 24'd0};
			dsh_q <= {den_q, 47'd0};
			quo_q <= '0;
		end else if (cmd.div_step) begin
			dsh_q <= dsh_q >> 1;
			if ({{(DSH_W-REM_W){1'b0}}, rem_q} >= dsh_q) begin
				rem_q <= rem_q - dsh_q[REM_W-1:0];
				quo_q <= {quo_q[MAG_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[MAG_W-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		case (cmd.acc_wr)
			ACC_ADD: begin
				acc_wdata.x = acc_add(acc_rd_q.x, term_x_q);
				acc_wdata.y = acc_add(acc_rd_q.y, term_y_q);
				acc_wdata.z = acc_add(acc_rd_q.z, term_z_q);
			end
			ACC_SUB: begin
				acc_wdata.x = acc_sub(acc_rd_q.x, term_x_q);
				acc_wdata.y = acc_sub(acc_rd_q.y, term_y_q);
				acc_wdata.z = acc_sub(acc_rd_q.z, term_z_q);
			end
			default: acc_wdata = '0;
		endcase
	end

	// Force accumulators: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.acc_wr != ACC_NONE) begin
			acc_mem[acc_waddr] <= acc_wdata;
		end
		acc_rd_q <= acc_mem[acc_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			result <= '{force_x: acc_rd_q.x, force_y: acc_rd_q.y,
				force_z: acc_rd_q.z, last_force: cmd.out_last};
		end
	end

	assign sts.skip = (r2_q == '0) || ({{(CUT_W-R2_W){1'b0}}, r2_q} > cutoff_q);

endmodule

// ===== hw/rtl/pcf_ctrl.sv =====
module pcf_ctrl import pcf_pkg::*; #(
	parameter int MAX_PARTICLES = MAX_PARTICLES_DEF,
	localparam int IW = $clog2(MAX_PARTICLES),
	localparam int CW = $clog2(MAX_PARTICLES + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          particle_valid,
	output logic          particle_ready,
	input  logic          last_in,
	output logic          result_valid,
	input  logic          result_ready,
	output logic [IW-1:0] st_waddr,
	output logic [IW-1:0] st_raddr_i,
	output logic [IW-1:0] st_raddr_j,
	output logic [IW-1:0] acc_waddr,
	output logic [IW-1:0] acc_raddr,
	output dp_cmd_t       cmd,
	input  dp_sts_t       sts
);

	typedef enum logic [24:0] {
		ST_IDLE    = 25'd1 << 0,
		ST_CLR     = 25'd1 << 1,
		ST_RD      = 25'd1 << 2,
		ST_DIFF    = 25'd1 << 3,
		ST_SQX     = 25'd1 << 4,
		ST_SQY     = 25'd1 << 5,
		ST_SQZ     = 25'd1 << 6,
		ST_MQ      = 25'd1 << 7,
		ST_CHK     = 25'd1 << 8,
		ST_SQRT_LD = 25'd1 << 9,
		ST_SQRT    = 25'd1 << 10,
		ST_DEN0    = 25'd1 << 11,
		ST_DEN1    = 25'd1 << 12,
		ST_DEN_W   = 25'd1 << 13,
		ST_DIV_LD  = 25'd1 << 14,
		ST_DIV     = 25'd1 << 15,
		ST_T0      = 25'd1 << 16,
		ST_T1      = 25'd1 << 17,
		ST_AR_I    = 25'd1 << 18,
		ST_AW_I    = 25'd1 << 19,
		ST_AW_J    = 25'd1 << 20,
		ST_NEXT    = 25'd1 << 21,
		ST_ORD     = 25'd1 << 22,
		ST_OLD     = 25'd1 << 23,
		ST_OUT     = 25'd1 << 24
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q, n_m1;
	logic [IW-1:0]     i_q, j_q, k_q;
	logic [STEP_W-1:0] step_q;
	axis_t             axis_q;
	logic              k_last;

	assign n_m1 = count_q - CW'(1);
	assign k_last = (CW'(k_q) == n_m1);

	assign particle_ready = (state_q == ST_IDLE);
	assign result_valid = (state_q == ST_OUT);
	assign st_waddr = count_q[IW-1:0];
	assign st_raddr_i = i_q;
	assign st_raddr_j = j_q;
	assign acc_raddr = (state_q == ST_AW_I) ? j_q : ((state_q == ST_ORD) ? k_q : i_q);
	assign acc_waddr = (state_q == ST_CLR) ? k_q : ((state_q == ST_AW_J) ? j_q : i_q);

	always_comb begin
		cmd = '0;
		cmd.axis = axis_q;
		cmd.out_last = k_last;
		case (state_q)
			ST_IDLE:    cmd.store_we = particle_valid && (count_q < CW'(MAX_PARTICLES));
			ST_CLR:     cmd.acc_wr = ACC_ZERO;
			ST_DIFF:    cmd.diff_ld = 1'b1;
			ST_SQX:     cmd.mul_op = MUL_SQX;
			ST_SQY:     cmd.mul_op = MUL_SQY;
			ST_SQZ:     cmd.mul_op = MUL_SQZ;
			ST_MQ:      cmd.mul_op = MUL_Q;
			ST_SQRT_LD: begin
				cmd.sqrt_ld = 1'b1;
				cmd.mul_op = MUL_NUM;
			end
			ST_SQRT:    cmd.sqrt_step = 1'b1;
			ST_DEN0:    cmd.mul_op = MUL_DEN0;
			ST_DEN1:    cmd.mul_op = MUL_DEN1;
			ST_DIV_LD:  cmd.div_ld = 1'b1;
			ST_DIV:     cmd.div_step = 1'b1;
			ST_T0:      cmd.mul_op = MUL_T0;
			ST_T1:      cmd.mul_op = MUL_T1;
			ST_AW_I:    cmd.acc_wr = ACC_ADD;
			ST_AW_J:    cmd.acc_wr = ACC_SUB;
			ST_OLD:     cmd.out_ld = 1'b1;
			default:    ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			step_q <= '0;
			axis_q <= AXIS_X;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (particle_valid) begin
						if (count_q < CW'(MAX_PARTICLES)) begin
							count_q <= count_q + CW'(1);
						end
						if (last_in) begin
							k_q <= '0;
							state_q <= ST_CLR;
						end
					end
				end
				ST_CLR: begin
					if (k_last) begin
						k_q <= '0;
						i_q <= '0;
						j_q <= IW'(1);
						state_q <= (count_q < CW'(2)) ? ST_ORD : ST_RD;
					end else begin
						k_q <= k_q + IW'(1);
					end
				end
				ST_RD:   state_q <= ST_DIFF;
				ST_DIFF: state_q <= ST_SQX;
				ST_SQX:  state_q <= ST_SQY;
				ST_SQY:  state_q <= ST_SQZ;
				ST_SQZ:  state_q <= ST_MQ;
				ST_MQ:   state_q <= ST_CHK;
				ST_CHK:  state_q <= sts.skip ? ST_NEXT : ST_SQRT_LD;
				ST_SQRT_LD: begin
					step_q <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (step_q == STEP_W'(SQRT_STEPS - 1)) begin
						state_q <= ST_DEN0;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_DEN0:  state_q <= ST_DEN1;
				ST_DEN1:  state_q <= ST_DEN_W;
				ST_DEN_W: state_q <= ST_DIV_LD;
				ST_DIV_LD: begin
					step_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						axis_q <= AXIS_X;
						state_q <= ST_T0;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_T0: state_q <= ST_T1;
				ST_T1: begin
					case (axis_q)
						AXIS_X: begin
							axis_q <= AXIS_Y;
							state_q <= ST_T0;
						end
						AXIS_Y: begin
							axis_q <= AXIS_Z;
							state_q <= ST_T0;
						end
						default: state_q <= ST_AR_I;
					endcase
				end
				ST_AR_I: state_q <= ST_AW_I;
				ST_AW_I: state_q <= ST_AW_J;
				ST_AW_J: state_q <= ST_NEXT;
				ST_NEXT: begin
					// Pairs run in ascending i, then ascending j above i.
					if (CW'(j_q) == n_m1) begin
						if (CW'(i_q) == n_m1 - CW'(1)) begin
							k_q <= '0;
							state_q <= ST_ORD;
						end else begin
							i_q <= i_q + IW'(1);
							j_q <= i_q + IW'(2);
							state_q <= ST_RD;
						end
					end else begin
						j_q <= j_q + IW'(1);
						state_q <= ST_RD;
					end
				end
				ST_ORD: state_q <= ST_OLD;
				ST_OLD: state_q <= ST_OUT;
				ST_OUT: begin
					if (result_ready) begin
						if (k_last) begin
							count_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							k_q <= k_q + IW'(1);
							state_q <= ST_ORD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_PARTICLES))
		else $error("particle count beyond store depth");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |-> (i_q < j_q) && (CW'(j_q) < count_q))
		else $error("pair indexes out of order");

	a_out_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (CW'(k_q) < count_q))
		else $error("result index beyond stored particles");

	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && particle_valid && last_in) |=> (state_q == ST_CLR))
		else $error("last particle did not start the evaluation");

endmodule
